// ----- rtl/core/irr_pkg.sv -----
`timescale 1ns / 1ps
package irr_pkg;

	localparam int FRAC_BITS_DEF = 30;
	localparam int COMP_W        = 32;
	localparam int MAG_W         = 64;
	// Width of a magnitude after the normalizing shift: leading one at bit 30.
	localparam int NRM_W         = 31;
	localparam int ROOT_STEPS    = MAG_W / 2;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef comp_t [2:0]              vec_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef mag_t [2:0]               mag_vec_t;

	// Cycles from the input register of a normalizer to its output register.
	function automatic int norm_lat(input int frac);
		return 5 + ROOT_STEPS + 1 + (frac + 1) + 1;
	endfunction

endpackage

// ----- rtl/core/inertial_to_rtc_rotation.sv -----
`timescale 1ns / 1ps
// Inertial state vector to radial/transverse/cross-track rotation matrix.
//
// Input channel (s_*): one transaction carries one state vector, position in
// metres and velocity in millimetres per second, all signed 32-bit.
// Output channel (m_*): one transaction per input carries the nine matrix
// entries in Q1.FRAC_BITS. Row 0 is the radial unit vector, row 1 the
// transverse unit vector (radial cross cross-track), row 2 the cross-track
// unit vector. tuser flags a degenerate input (zero position or zero r x v);
// the matrix is then all zero.
//
// The block is a fully pipelined datapath: a new transaction can enter in
// every cycle in which the output does not stall. Two normalizer passes in
// series make up most of the pipeline, each with a 32-stage square root and
// a FRAC_BITS + 1 stage divider.
// The whole pipeline advances together. When the receiver holds off m_tready
// while a result waits, every stage freezes and s_tready drops, so nothing is
// lost or repeated. Reset clears all valid bits; no transaction is in flight.
module inertial_to_rtc_rotation import irr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic [287:0] m_tdata,
	// degenerate
	output logic         m_tuser
);

	localparam int LAT  = norm_lat(FRAC_BITS);
	localparam int UNIT = 1 << FRAC_BITS;

	typedef struct packed {
		vec_t rad;
		vec_t crs;
		logic ok;
	} rows_t;

	// The pipeline moves whenever the output register is empty or being drained.
	logic adv;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Stage 1: input register.
	logic v_s1;
	vec_t r_s1;
	vec_t w_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				r_s1[i] <= s_tdata[COMP_W*i +: COMP_W];
				w_s1[i] <= s_tdata[COMP_W*(i+3) +: COMP_W];
			end
		end
	end

	// Stage 2: the six products of r x v, and the position magnitudes.
	logic                    v_s2;
	logic signed [MAG_W-1:0] p_s2 [0:5];
	mag_vec_t                rmag_s2;
	logic [2:0]              rneg_s2;
	logic [2:0][COMP_W:0]    rabs_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (r_s1[i][COMP_W-1]) begin
				rabs_c[i] = -{r_s1[i][COMP_W-1], r_s1[i]};
			end else begin
				rabs_c[i] = {1'b0, r_s1[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0] <= $signed(r_s1[1]) * $signed(w_s1[2]);
			p_s2[1] <= $signed(r_s1[2]) * $signed(w_s1[1]);
			p_s2[2] <= $signed(r_s1[2]) * $signed(w_s1[0]);
			p_s2[3] <= $signed(r_s1[0]) * $signed(w_s1[2]);
			p_s2[4] <= $signed(r_s1[0]) * $signed(w_s1[1]);
			p_s2[5] <= $signed(r_s1[1]) * $signed(w_s1[0]);
			for (int i = 0; i < 3; i++) begin
				rmag_s2[i] <= MAG_W'(rabs_c[i]);
				rneg_s2[i] <= r_s1[i][COMP_W-1];
			end
		end
	end

	// Stage 3: exact differences as sign and magnitude.
	logic                  v_s3;
	mag_vec_t              cmag_s3;
	logic [2:0]            cneg_s3;
	mag_vec_t              rmag_s3;
	logic [2:0]            rneg_s3;
	logic signed [MAG_W:0] cd_c [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cd_c[i] = $signed({p_s2[2*i][MAG_W-1], p_s2[2*i]})
				- $signed({p_s2[2*i+1][MAG_W-1], p_s2[2*i+1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rmag_s3 <= rmag_s2;
			rneg_s3 <= rneg_s2;
			for (int i = 0; i < 3; i++) begin
				cneg_s3[i] <= cd_c[i][MAG_W];
				if (cd_c[i][MAG_W]) begin
					cmag_s3[i] <= MAG_W'(-cd_c[i]);
				end else begin
					cmag_s3[i] <= MAG_W'(cd_c[i]);
				end
			end
		end
	end

	// Radial and cross-track normalizers run side by side.
	logic rad_valid;
	vec_t rad_vec;
	logic rad_zero;
	logic crs_valid;
	vec_t crs_vec;
	logic crs_zero;

	irr_norm #(
		.FRAC_BITS (FRAC_BITS)
	) u_rad (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s3),
		.in_mag    (rmag_s3),
		.in_neg    (rneg_s3),
		.out_valid (rad_valid),
		.out_vec   (rad_vec),
		.out_zero  (rad_zero)
	);

	irr_norm #(
		.FRAC_BITS (FRAC_BITS)
	) u_crs (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s3),
		.in_mag    (cmag_s3),
		.in_neg    (cneg_s3),
		.out_valid (crs_valid),
		.out_vec   (crs_vec),
		.out_zero  (crs_zero)
	);

	// Stage 4: products of radial x cross-track.
	logic                    v_s4;
	logic signed [MAG_W-1:0] q_s4 [0:5];
	rows_t                   rows_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= rad_valid & crs_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4[0]     <= $signed(rad_vec[1]) * $signed(crs_vec[2]);
			q_s4[1]     <= $signed(rad_vec[2]) * $signed(crs_vec[1]);
			q_s4[2]     <= $signed(rad_vec[2]) * $signed(crs_vec[0]);
			q_s4[3]     <= $signed(rad_vec[0]) * $signed(crs_vec[2]);
			q_s4[4]     <= $signed(rad_vec[0]) * $signed(crs_vec[1]);
			q_s4[5]     <= $signed(rad_vec[1]) * $signed(crs_vec[0]);
			rows_s4.rad <= rad_vec;
			rows_s4.crs <= crs_vec;
			rows_s4.ok  <= !rad_zero && !crs_zero;
		end
	end

	// Stage 5: transverse components as sign and magnitude.
	logic                  v_s5;
	mag_vec_t              tmag_s5;
	logic [2:0]            tneg_s5;
	logic signed [MAG_W:0] td_c [0:2];
	rows_t                 dl_s [0:LAT];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			td_c[i] = $signed({q_s4[2*i][MAG_W-1], q_s4[2*i]})
				- $signed({q_s4[2*i+1][MAG_W-1], q_s4[2*i+1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dl_s[0] <= rows_s4;
			for (int i = 0; i < 3; i++) begin
				tneg_s5[i] <= td_c[i][MAG_W];
				if (td_c[i][MAG_W]) begin
					tmag_s5[i] <= MAG_W'(-td_c[i]);
				end else begin
					tmag_s5[i] <= MAG_W'(td_c[i]);
				end
			end
		end
	end

	// Radial and cross-track rows wait alongside the transverse normalizer.
	for (genvar k = 0; k < LAT; k++) begin : g_delay
		always_ff @(posedge clk) begin
			if (adv) begin
				dl_s[k+1] <= dl_s[k];
			end
		end
	end

	logic trn_valid;
	vec_t trn_vec;
	logic trn_zero;

	irr_norm #(
		.FRAC_BITS (FRAC_BITS)
	) u_trn (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s5),
		.in_mag    (tmag_s5),
		.in_neg    (tneg_s5),
		.out_valid (trn_valid),
		.out_vec   (trn_vec),
		.out_zero  (trn_zero)
	);

	// The normalizer output registers double as the output stage.
	logic ok;

	assign ok       = dl_s[LAT].ok && !trn_zero;
	assign m_tvalid = trn_valid;
	assign m_tuser  = !ok;
	assign m_tdata  = ok ? {dl_s[LAT].crs, trn_vec, dl_s[LAT].rad} : '0;

	// A degenerate result carries an all-zero matrix.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate result with nonzero matrix");

	// A valid radial row is never all zero.
	a_rad_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[3*COMP_W-1:0] != '0)
		else $error("radial row is zero on a valid result");

	// Entries m00 and m20 stay within plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
			$signed(m_tdata[COMP_W-1:0]) <= UNIT &&
			$signed(m_tdata[COMP_W-1:0]) >= -UNIT &&
			$signed(m_tdata[7*COMP_W-1:6*COMP_W]) <= UNIT &&
			$signed(m_tdata[7*COMP_W-1:6*COMP_W]) >= -UNIT)
		else $error("matrix entry out of range");

	// An empty output stage never blocks the input.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output is empty");

endmodule

// ----- rtl/core/irr_norm.sv -----
`timescale 1ns / 1ps
module irr_norm import irr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  mag_vec_t in_mag,
	input  logic [2:0] in_neg,
	output logic     out_valid,
	output vec_t     out_vec,
	output logic     out_zero
);

	localparam int POS_W     = $clog2(MAG_W);
	localparam int NBYTES    = MAG_W / 8;
	localparam int DW        = NRM_W + FRAC_BITS + 1;
	localparam int QW        = FRAC_BITS + 1;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int NW        = ROOT_STEPS;
	localparam logic [POS_W-1:0] TOP_POS = POS_W'(NRM_W - 1);

	typedef struct packed {
		logic [2:0][NRM_W-1:0] sh;
		logic [2:0]            neg;
		logic                  zero;
	} nrm_t;

	// Stage 1: leading-one search, first per byte.
	logic [MAG_W-1:0]       any_c;
	logic [NBYTES-1:0]      bnz_c;
	logic [NBYTES-1:0][2:0] bpos_c;

	assign any_c = in_mag[0] | in_mag[1] | in_mag[2];

	always_comb begin
		for (int g = 0; g < NBYTES; g++) begin
			bnz_c[g]  = |any_c[8*g +: 8];
			bpos_c[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (any_c[8*g + b]) begin
					bpos_c[g] = 3'(b);
				end
			end
		end
	end

	logic                   v_s1;
	mag_vec_t               mag_s1;
	logic [2:0]             neg_s1;
	logic [NBYTES-1:0]      bnz_s1;
	logic [NBYTES-1:0][2:0] bpos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= in_mag;
			neg_s1  <= in_neg;
			bnz_s1  <= bnz_c;
			bpos_s1 <= bpos_c;
		end
	end

	// Stage 2: combine the byte results into one bit position.
	logic [POS_W-1:0] pos_c;

	always_comb begin
		pos_c = '0;
		for (int g = 0; g < NBYTES; g++) begin
			if (bnz_s1[g]) begin
				pos_c = {3'(g), bpos_s1[g]};
			end
		end
	end

	logic             v_s2;
	mag_vec_t         mag_s2;
	logic [2:0]       neg_s2;
	logic [POS_W-1:0] pos_s2;
	logic             zero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			pos_s2  <= pos_c;
			zero_s2 <= ~|bnz_s1;
		end
	end

	// Stage 3: move the leading one of the largest magnitude to the top bit.
	nrm_t nrm_c;

	always_comb begin
		nrm_c.neg  = neg_s2;
		nrm_c.zero = zero_s2;
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 > TOP_POS) begin
				nrm_c.sh[i] = NRM_W'(mag_s2[i] >> (pos_s2 - TOP_POS));
			end else begin
				nrm_c.sh[i] = NRM_W'(mag_s2[i] << (TOP_POS - pos_s2));
			end
		end
	end

	logic v_s3;
	nrm_t nrm_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_s3 <= nrm_c;
		end
	end

	// Stage 4: squares. Stage 5: their sum.
	logic                      v_s4;
	nrm_t                      nrm_s4;
	logic [2:0][2*NRM_W-1:0]   sq_s4;
	logic                      v_s5;
	nrm_t                      nrm_s5;
	logic [MAG_W-1:0]          sum_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_s4 <= nrm_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= nrm_s3.sh[i] * nrm_s3.sh[i];
			end
			nrm_s5 <= nrm_s4;
			sum_s5 <= MAG_W'(sq_s4[0]) + MAG_W'(sq_s4[1]) + MAG_W'(sq_s4[2]);
		end
	end

	// Square root, one result bit per stage.
	logic [MAG_W-1:0] rt_x_s [0:ROOT_STEPS];
	logic [MAG_W-1:0] rt_r_s [0:ROOT_STEPS];
	nrm_t             rt_c_s [0:ROOT_STEPS];
	logic             rt_v_s [0:ROOT_STEPS];

	assign rt_x_s[0] = sum_s5;
	assign rt_r_s[0] = '0;
	assign rt_c_s[0] = nrm_s5;
	assign rt_v_s[0] = v_s5;

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [MAG_W-1:0] BIT = MAG_W'(1) << (MAG_W - 2 - 2*k);
		logic [MAG_W-1:0] trial;

		assign trial = rt_r_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_c_s[k+1] <= rt_c_s[k];
				if (rt_x_s[k] >= trial) begin
					rt_x_s[k+1] <= rt_x_s[k] - trial;
					rt_r_s[k+1] <= (rt_r_s[k] >> 1) + BIT;
				end else begin
					rt_x_s[k+1] <= rt_x_s[k];
					rt_r_s[k+1] <= rt_r_s[k] >> 1;
				end
			end
		end
	end

	// Divider setup: dividend is the scaled magnitude plus half the norm.
	logic [NW-1:0]          root_c;
	logic [2:0][DW-1:0]     dvd_c;

	assign root_c = rt_r_s[ROOT_STEPS][NW-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dvd_c[i] = (DW'(rt_c_s[ROOT_STEPS].sh[i]) << FRAC_BITS) + DW'(root_c >> 1);
		end
	end

	logic [2:0][DW-1:0] dv_d_s   [0:DIV_STEPS];
	logic [2:0][NW-1:0] dv_rem_s [0:DIV_STEPS];
	logic [2:0][QW-1:0] dv_q_s   [0:DIV_STEPS];
	logic [NW-1:0]      dv_n_s   [0:DIV_STEPS];
	logic [2:0]         dv_neg_s [0:DIV_STEPS];
	logic               dv_zero_s[0:DIV_STEPS];
	logic               dv_v_s   [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= rt_v_s[ROOT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_d_s[0]    <= dvd_c;
			dv_n_s[0]    <= root_c;
			dv_neg_s[0]  <= rt_c_s[ROOT_STEPS].neg;
			dv_zero_s[0] <= rt_c_s[ROOT_STEPS].zero;
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= NW'(dvd_c[i][DW-1:FRAC_BITS+1]);
				dv_q_s[0][i]   <= '0;
			end
		end
	end

	// Restoring division, one quotient bit per stage for all three components.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [2:0][NW:0] part;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				part[i] = {dv_rem_s[j][i], dv_d_s[j][i][FRAC_BITS - j]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_d_s[j+1]    <= dv_d_s[j];
				dv_n_s[j+1]    <= dv_n_s[j];
				dv_neg_s[j+1]  <= dv_neg_s[j];
				dv_zero_s[j+1] <= dv_zero_s[j];
				for (int i = 0; i < 3; i++) begin
					if (part[i] >= {1'b0, dv_n_s[j]}) begin
						dv_rem_s[j+1][i] <= NW'(part[i] - {1'b0, dv_n_s[j]});
						dv_q_s[j+1][i]   <= {dv_q_s[j][i][QW-2:0], 1'b1};
					end else begin
						dv_rem_s[j+1][i] <= NW'(part[i]);
						dv_q_s[j+1][i]   <= {dv_q_s[j][i][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Output register: sign applied, all zero when the vector was zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_zero <= dv_zero_s[DIV_STEPS];
			for (int i = 0; i < 3; i++) begin
				if (dv_zero_s[DIV_STEPS]) begin
					out_vec[i] <= '0;
				end else if (dv_neg_s[DIV_STEPS][i]) begin
					out_vec[i] <= -COMP_W'(dv_q_s[DIV_STEPS][i]);
				end else begin
					out_vec[i] <= COMP_W'(dv_q_s[DIV_STEPS][i]);
				end
			end
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import irr_pkg::*;

	// The testbench runs the block at its default fraction width.
	localparam int FRAC    = FRAC_BITS_DEF;
	localparam int LATENCY = 2 * FRAC + 85;
	localparam int N_RAND  = 1400;

	// One result transaction as the output port carries it.
	typedef struct {
		logic [8:0][31:0] entry;
		logic             degenerate;
	} rotation_t;

	// Keeps the rotations still due from the block, in order of acceptance. Each one is
	// computed in exact integer arithmetic from the accepted state vector.
	class rotation_scoreboard;
		rotation_t due[$];
		int        errors = 0;

		// Integer square root by the digit-by-digit method, floor of the true root.
		function bit [63:0] root64(bit [63:0] x);
			bit [63:0] res;
			bit [63:0] one;
			res = 0;
			one = 64'd1 << 62;
			while (one > x) one = one >> 2;
			while (one != 0) begin
				if (x >= res + one) begin
					x   = x - (res + one);
					res = (res >> 1) + one;
				end else begin
					res = res >> 1;
				end
				one = one >> 2;
			end
			return res;
		endfunction

		// Scales a sign/magnitude triple to a unit vector in Q1.FRAC. Returns 0 for the
		// zero vector, in which case the output is zero.
		function bit to_unit(input bit [2:0][63:0] mag, input bit [2:0] neg,
				output longint q [3]);
			bit [63:0] peak;
			bit [63:0] sum;
			bit [63:0] norm;
			bit [63:0] quo;
			peak = mag[0];
			if (mag[1] > peak) peak = mag[1];
			if (mag[2] > peak) peak = mag[2];
			for (int i = 0; i < 3; i++) q[i] = 0;
			if (peak == 0) return 0;
			while (peak >= (64'd1 << 31)) begin
				peak = peak >> 1;
				for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
			end
			while (peak < (64'd1 << 30)) begin
				peak = peak << 1;
				for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
			end
			sum  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
			norm = root64(sum);
			for (int i = 0; i < 3; i++) begin
				quo  = ((mag[i] << FRAC) + (norm >> 1)) / norm;
				q[i] = neg[i] ? -longint'(quo) : longint'(quo);
			end
			return 1;
		endfunction

		// Exact cross product a x b, as sign and magnitude per component.
		function void cross3(input longint a [3], input longint b [3],
				output bit [2:0][63:0] mag, output bit [2:0] neg);
			longint p1;
			longint p2;
			for (int i = 0; i < 3; i++) begin
				p1 = a[(i + 1) % 3] * b[(i + 2) % 3];
				p2 = a[(i + 2) % 3] * b[(i + 1) % 3];
				neg[i] = p1 < p2;
				mag[i] = neg[i] ? 64'(p2 - p1) : 64'(p1 - p2);
			end
		endfunction

		// Notes an accepted state vector and queues the rotation it must produce.
		function void note_state(logic [191:0] sv);
			longint          r [3];
			longint          v [3];
			longint          rad [3];
			longint          crs [3];
			longint          trn [3];
			bit [2:0][63:0]  mag;
			bit [2:0]        neg;
			bit              ok;
			rotation_t       rot;
			for (int i = 0; i < 3; i++) begin
				r[i]   = longint'($signed(sv[32*i +: 32]));
				v[i]   = longint'($signed(sv[32*(i+3) +: 32]));
				neg[i] = r[i] < 0;
				mag[i] = neg[i] ? 64'(-r[i]) : 64'(r[i]);
			end
			ok = to_unit(mag, neg, rad);
			cross3(r, v, mag, neg);
			ok = to_unit(mag, neg, crs) & ok;
			// Transverse keeps the operand order radial x cross-track.
			cross3(rad, crs, mag, neg);
			ok = to_unit(mag, neg, trn) & ok;
			for (int i = 0; i < 3; i++) begin
				rot.entry[i]     = ok ? rad[i][31:0] : 32'd0;
				rot.entry[3 + i] = ok ? trn[i][31:0] : 32'd0;
				rot.entry[6 + i] = ok ? crs[i][31:0] : 32'd0;
			end
			rot.degenerate = !ok;
			due.push_back(rot);
		endfunction

		// Compares one accepted result transaction with the oldest rotation still due.
		function void check_rotation(logic [287:0] data, logic degen);
			rotation_t want;
			string     names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
				"m20", "m21", "m22"};
			if (due.size() == 0) begin
				$error("result transaction with no rotation due");
				errors++;
				return;
			end
			want = due.pop_front();
			for (int i = 0; i < 9; i++) begin
				if (data[32*i +: 32] !== want.entry[i]) begin
					$error("%s: expected %0d, got %0d", names[i],
						$signed(want.entry[i]), $signed(data[32*i +: 32]));
					errors++;
				end
			end
			if (degen !== want.degenerate) begin
				$error("degenerate: expected %0d, got %0d", want.degenerate, degen);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// m00, m01, m02, m10, m11, m12, m20, m21, m22
	logic [287:0] m_tdata;
	// degenerate
	logic         m_tuser;

	rotation_scoreboard sb = new();

	// Sender burst state: items left in the current burst.
	int burst_left = 0;

	inertial_to_rtc_rotation u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one state vector and holds it until the block takes it. The valid line is
	// left high for the next item inside a burst; a gap only opens between bursts, so
	// gaps land at random points of the pipeline's work.
	task automatic send_state(input logic [31:0] px, py, pz, vx, vy, vz);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {vz, vy, vx, pz, py, px};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_state({vz, vy, vx, pz, py, px});
		burst_left--;
	endtask

	// Random 32-bit value whose magnitude is spread over all bit lengths.
	function automatic logic [31:0] rand_word();
		int sh;
		sh = $urandom_range(0, 31);
		return $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom()) >>> sh);
	endfunction

	// Receiver: a stall pattern drawn anew at random from four modes, plus one
	// long hold-off that fills the pipeline while the sender keeps offering items.
	initial begin
		int cyc;
		int mode;
		cyc  = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 200 == 0) mode = $urandom_range(0, 3);
			if (cyc >= 600 && cyc < 1000)
				m_tready <= 1'b0;
			else case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((cyc / 7) % 3 != 0);
			endcase
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_rotation(m_tdata, m_tuser);
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [31:0] p [3];
		int          k;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: both zero-position and zero r x v cases, parallel and antiparallel
		// vectors, an extreme value in every field, and a typical low orbit.
		send_state(0, 0, 0, 0, 0, 0);
		send_state(0, 0, 0, 7500000, 0, 0);
		send_state(7000000, 0, 0, 0, 0, 0);
		send_state(1000, 2000, 3000, 2000, 4000, 6000);
		send_state(5, -7, 9, -10, 14, -18);
		send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_state(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_state(32'h8000_0000, 0, 0, 0, 32'h7fff_ffff, 0);
		send_state(32'h7fff_ffff, 0, 0, 0, 0, 32'h8000_0000);
		send_state(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000, 1);
		send_state(1, 0, 0, 0, 1, 0);
		send_state(0, 0, -1, -1, 0, 0);
		send_state(1, 1, 1, 1, -1, 0);
		send_state(7000000, 0, 0, 0, 7500000, 0);
		send_state(-4000000, 5000000, 2500000, -3000, -5500000, 4200000);
		send_state(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 2, 3);
		send_state(42164000, 0, 0, 0, 3074660, 0);

		// Random part: mostly arbitrary patterns, plus orbit-like vectors and
		// near-degenerate (scaled parallel) pairs.
		for (int n = 0; n < N_RAND; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_state($urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom());
				4, 5, 6: send_state(rand_word(), rand_word(), rand_word(),
					rand_word(), rand_word(), rand_word());
				7, 8: send_state(32'($urandom_range(0, 80000000)) - 32'd40000000,
					32'($urandom_range(0, 80000000)) - 32'd40000000,
					32'($urandom_range(0, 80000000)) - 32'd40000000,
					32'($urandom_range(0, 16000000)) - 32'd8000000,
					32'($urandom_range(0, 16000000)) - 32'd8000000,
					32'($urandom_range(0, 16000000)) - 32'd8000000);
				default: begin
					for (int i = 0; i < 3; i++)
						p[i] = 32'($urandom_range(0, 2000)) - 32'd1000;
					k = $urandom_range(0, 2000) - 1000;
					send_state(p[0], p[1], p[2], p[0] * k, p[1] * k, p[2] * k);
				end
			endcase
		end
		s_tvalid <= 1'b0;

		while (sb.due.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/irr_pkg.sv
rtl/core/irr_norm.sv
rtl/core/inertial_to_rtc_rotation.sv
tb/tb.sv
